// ----- hw/rtl/dsd_pkg.sv -----
// shared constants, types and the month table of the date shift unit
// no dependencies
`default_nettype none

package dsd_pkg;

  // pipeline depth, one register stage per entry
  localparam int unsigned STAGES = 15;

  // calendar constants
  localparam int unsigned EPOCH_ADJ      = 306;
  localparam int unsigned DAY_NUMBER_MAX = 3652059;

  // reciprocal of 25 scaled by 2^15, exact for dividends below 4681
  localparam int unsigned RECIP_25    = 1311;
  localparam int unsigned RECIP_25_SH = 15;

  // reciprocal of 153 scaled by 2^20, exact for dividends below 12192
  localparam int unsigned RECIP_153    = 6854;
  localparam int unsigned RECIP_153_SH = 20;

  // constant dividers: floor(2^32 / divisor), one correction step after
  localparam int unsigned DIV_SHIFT = 32;
  localparam int unsigned DIV_CENT  = 146097;
  localparam int unsigned RECIP_CENT = 29398;
  localparam int unsigned DIV_YEAR  = 1461;
  localparam int unsigned RECIP_YEAR = 2939744;

  // beat carried alongside a constant division
  typedef struct packed {
    logic [21:0] z;       // shifted day number plus epoch, later plus century term
    logic [21:0] start;   // day number of the input date, low bits
    logic        oor;     // shifted date out of range
  } side_t;

  // days from march 1 to the first of month m, months 13 and 14 are jan and feb
  function automatic logic [8:0] month_offset(input logic [4:0] m);
    logic [8:0] r;
    case (m)
      5'd3:         r = 9'd0;
      5'd4:         r = 9'd31;
      5'd5:         r = 9'd61;
      5'd6:         r = 9'd92;
      5'd7:         r = 9'd122;
      5'd8:         r = 9'd153;
      5'd9:         r = 9'd184;
      5'd10:        r = 9'd214;
      5'd11:        r = 9'd245;
      5'd0, 5'd12:  r = 9'd275;
      5'd1, 5'd13:  r = 9'd306;
      5'd2, 5'd14:  r = 9'd337;
      5'd15:        r = 9'd367;
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/date_shift_by_days_unit.sv -----
// date shift unit: gregorian date plus signed day offset, fifteen stage pipeline
// one beat per cycle sustained while the output is not stalled
// a stalled output holds its stage; earlier stages keep filling any empty slots
// reset clears the valid bits only, data registers are not reset
// depends on dsd_pkg, dsd_ctrl, dsd_fwd, dsd_cdiv, dsd_ymd
`default_nettype none

module date_shift_by_days_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [13:0]        year_in_i,
  input  wire logic [3:0]         month_in_i,
  input  wire logic [4:0]         day_in_i,
  input  wire logic signed [22:0] offset_days_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [13:0]             year_out_o,
  output logic [3:0]              month_out_o,
  output logic [4:0]              day_out_o,
  output logic [21:0]             day_number_in_o,
  output logic                    out_of_range_o
);

  logic [dsd_pkg::STAGES-1:0] en;
  logic [23:0]                x_cent;
  dsd_pkg::side_t             side_fwd, side_cent, side_mid_q, side_year;
  logic [6:0]                 cent;
  logic [6:0]                 b;
  logic [23:0]                x_year;
  logic [13:0]                yy;

  dsd_ctrl #(
    .STAGES (dsd_pkg::STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  dsd_fwd u_fwd (
    .clk_i    (clk_i),
    .en_i     (en[3:0]),
    .year_i   (year_in_i),
    .month_i  (month_in_i),
    .day_i    (day_in_i),
    .offset_i (offset_days_i),
    .x_o      (x_cent),
    .side_o   (side_fwd)
  );

  dsd_cdiv #(
    .XW      (24),
    .QW      (7),
    .MW      (15),
    .DW      (18),
    .DIVISOR (dsd_pkg::DIV_CENT),
    .RECIP   (dsd_pkg::RECIP_CENT)
  ) u_cent_div (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .x_i    (x_cent),
    .side_i (side_fwd),
    .q_o    (cent),
    .side_o (side_cent)
  );

  // century correction folded into the day count
  assign b = cent - {2'b00, cent[6:2]};

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      side_mid_q.z     <= side_cent.z + 22'(b);
      side_mid_q.start <= side_cent.start;
      side_mid_q.oor   <= side_cent.oor;
    end
  end

  assign x_year = {side_mid_q.z, 2'b00} - 24'd1;

  dsd_cdiv #(
    .XW      (24),
    .QW      (14),
    .MW      (22),
    .DW      (11),
    .DIVISOR (dsd_pkg::DIV_YEAR),
    .RECIP   (dsd_pkg::RECIP_YEAR)
  ) u_year_div (
    .clk_i  (clk_i),
    .en_i   (en[10:8]),
    .x_i    (x_year),
    .side_i (side_mid_q),
    .q_o    (yy),
    .side_o (side_year)
  );

  dsd_ymd u_ymd (
    .clk_i        (clk_i),
    .en_i         (en[14:11]),
    .yy_i         (yy),
    .side_i       (side_year),
    .year_o       (year_out_o),
    .month_o      (month_out_o),
    .day_o        (day_out_o),
    .day_number_o (day_number_in_o),
    .oor_o        (out_of_range_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dsd_ctrl.sv -----
// valid bits and per-stage load enables of the date shift pipeline
// no dependencies
`default_nettype none

module dsd_ctrl #(
  parameter int unsigned STAGES = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [STAGES-1:0]      en_o
);

  logic [STAGES-1:0] vld_q, vld_d;

  // a stage moves unless it and every stage after it is full and the output stalls
  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en_o[k] = !(out_stall_i && (&vld_q[STAGES-1:k]));
  end

  always_comb begin
    vld_d[0] = en_o[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en_o[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en_o[0];
  assign out_valid_o = vld_q[STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/dsd_fwd.sv -----
// date to day number, offset add and range check, four register stages
// depends on dsd_pkg
`default_nettype none

module dsd_fwd (
  input  wire logic               clk_i,
  input  wire logic [3:0]         en_i,
  input  wire logic [13:0]        year_i,
  input  wire logic [3:0]         month_i,
  input  wire logic [4:0]         day_i,
  input  wire logic signed [22:0] offset_i,
  output logic [23:0]             x_o,
  output dsd_pkg::side_t          side_o
);

  // stage 0
  logic signed [14:0] ym_q, ym_d;
  logic [13:0]        yp_q, yp_d;
  logic [4:0]         day0_q;
  logic [8:0]         mtab0_q;
  logic signed [22:0] off0_q;
  // stage 1
  logic signed [23:0] p365_q, p365_d;
  logic [11:0]        q4_q;
  logic [22:0]        c100_q, c100_d;
  logic [20:0]        c400_q, c400_d;
  logic [4:0]         day1_q;
  logic [8:0]         mtab1_q;
  logic signed [22:0] off1_q;
  // stage 2
  logic signed [24:0] start_q, start_d;
  logic signed [22:0] off2_q;
  // stage 3
  logic signed [25:0] target;
  logic [21:0]        z_d;
  logic               oor_d;
  logic [23:0]        x_q;
  dsd_pkg::side_t     side_q;

  // january and february count as months of the year before
  always_comb begin
    ym_d = $signed({1'b0, year_i}) - $signed({14'd0, (month_i < 4'd3)});
    yp_d = ym_d[14] ? 14'd0 : ym_d[13:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ym_q    <= ym_d;
      yp_q    <= yp_d;
      day0_q  <= day_i;
      mtab0_q <= dsd_pkg::month_offset({1'b0, month_i});
      off0_q  <= offset_i;
    end
  end

  always_comb begin
    p365_d = 24'(ym_q) * 24'sd365;
    c100_d = 23'(yp_q[13:2]) * 23'(dsd_pkg::RECIP_25);
    c400_d = 21'(yp_q[13:4]) * 21'(dsd_pkg::RECIP_25);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p365_q  <= p365_d;
      q4_q    <= yp_q[13:2];
      c100_q  <= c100_d;
      c400_q  <= c400_d;
      day1_q  <= day0_q;
      mtab1_q <= mtab0_q;
      off1_q  <= off0_q;
    end
  end

  always_comb begin
    start_d = 25'(p365_q)
            + $signed(25'(day1_q))
            + $signed(25'(mtab1_q))
            + $signed(25'(q4_q))
            - $signed(25'(c100_q[22:dsd_pkg::RECIP_25_SH]))
            + $signed(25'(c400_q[20:dsd_pkg::RECIP_25_SH]))
            - $signed(25'(dsd_pkg::EPOCH_ADJ));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      start_q <= start_d;
      off2_q  <= off1_q;
    end
  end

  always_comb begin
    target = 26'(start_q) + 26'(off2_q);
    oor_d  = (target < 26'sd1) || (target > $signed(26'(dsd_pkg::DAY_NUMBER_MAX)));
    z_d    = 22'(target) + 22'(dsd_pkg::EPOCH_ADJ);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x_q          <= {z_d, 2'b00} - 24'd1;
      side_q.z     <= z_d;
      side_q.start <= start_q[21:0];
      side_q.oor   <= oor_d;
    end
  end

  assign x_o    = x_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dsd_cdiv.sv -----
// division by a constant: reciprocal multiply, back multiply, one correction
// three register stages, depends on dsd_pkg
`default_nettype none

module dsd_cdiv #(
  parameter int unsigned XW      = 24,
  parameter int unsigned QW      = 7,
  parameter int unsigned MW      = 15,
  parameter int unsigned DW      = 18,
  parameter int unsigned DIVISOR = 146097,
  parameter int unsigned RECIP   = 29398
) (
  input  wire logic           clk_i,
  input  wire logic [2:0]     en_i,
  input  wire logic [XW-1:0]  x_i,
  input  wire dsd_pkg::side_t side_i,
  output logic [QW-1:0]       q_o,
  output dsd_pkg::side_t      side_o
);

  localparam int unsigned PW = XW + MW;
  localparam int unsigned BW = QW + DW;

  logic [PW-1:0]  prod_q;
  logic [XW-1:0]  x0_q, x1_q;
  dsd_pkg::side_t side0_q, side1_q, side2_q;
  logic [QW-1:0]  qe_q;
  logic [BW-1:0]  back_q;
  logic [XW-1:0]  rem;
  logic [QW-1:0]  q_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q  <= PW'(x_i) * PW'(RECIP);
      x0_q    <= x_i;
      side0_q <= side_i;
    end
  end

  // estimate is exact or one low
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      qe_q    <= prod_q[dsd_pkg::DIV_SHIFT +: QW];
      back_q  <= BW'(prod_q[dsd_pkg::DIV_SHIFT +: QW]) * BW'(DIVISOR);
      x1_q    <= x0_q;
      side1_q <= side0_q;
    end
  end

  assign rem = x1_q - XW'(back_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      q_q     <= qe_q + QW'(rem >= XW'(DIVISOR));
      side2_q <= side1_q;
    end
  end

  assign q_o    = q_q;
  assign side_o = side2_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dsd_ymd.sv -----
// year, day of year and month split of the shifted day number, four stages
// depends on dsd_pkg
`default_nettype none

module dsd_ymd (
  input  wire logic           clk_i,
  input  wire logic [3:0]     en_i,
  input  wire logic [13:0]    yy_i,
  input  wire dsd_pkg::side_t side_i,
  output logic [13:0]         year_o,
  output logic [3:0]          month_o,
  output logic [4:0]          day_o,
  output logic [21:0]         day_number_o,
  output logic                oor_o
);

  // stage 0
  logic [22:0]    p365_q;
  logic [11:0]    q4_q;
  logic [13:0]    yy0_q;
  dsd_pkg::side_t side0_q;
  // stage 1
  logic [8:0]     c1_q;
  logic [13:0]    yy1_q;
  logic [21:0]    start1_q;
  logic           oor1_q;
  logic [22:0]    c_full;
  // stage 2
  logic [24:0]    prod_q;
  logic [11:0]    xm;
  logic [8:0]     c2_q;
  logic [13:0]    yy2_q;
  logic [21:0]    start2_q;
  logic           oor2_q;
  // stage 3
  logic [4:0]     mm;
  logic [8:0]     dd;
  logic [13:0]    year_d;
  logic [4:0]     month_d;
  logic [13:0]    year_q;
  logic [3:0]     month_q;
  logic [4:0]     day_q;
  logic [21:0]    start3_q;
  logic           oor3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p365_q  <= 23'(yy_i) * 23'd365;
      q4_q    <= yy_i[13:2];
      yy0_q   <= yy_i;
      side0_q <= side_i;
    end
  end

  // day of the year counted from march 1
  assign c_full = 23'(side0_q.z) - p365_q - 23'(q4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      c1_q     <= c_full[8:0];
      yy1_q    <= yy0_q;
      start1_q <= side0_q.start;
      oor1_q   <= side0_q.oor;
    end
  end

  assign xm = 12'(c1_q) * 12'd5 + 12'd456;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q   <= 25'(xm) * 25'(dsd_pkg::RECIP_153);
      c2_q     <= c1_q;
      yy2_q    <= yy1_q;
      start2_q <= start1_q;
      oor2_q   <= oor1_q;
    end
  end

  always_comb begin
    mm = prod_q[dsd_pkg::RECIP_153_SH +: 5];
    dd = c2_q - dsd_pkg::month_offset(mm);
    if (mm > 5'd12) begin
      year_d  = yy2_q + 14'd1;
      month_d = mm - 5'd12;
    end else begin
      year_d  = yy2_q;
      month_d = mm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      year_q   <= oor2_q ? 14'd0 : year_d;
      month_q  <= oor2_q ? 4'd0 : month_d[3:0];
      day_q    <= oor2_q ? 5'd0 : dd[4:0];
      start3_q <= start2_q;
      oor3_q   <= oor2_q;
    end
  end

  assign year_o       = year_q;
  assign month_o      = month_q;
  assign day_o        = day_q;
  assign day_number_o = start3_q;
  assign oor_o        = oor3_q;

endmodule

`default_nettype wire

// ----- sim/tb_date_shift_by_days_unit.sv -----
// self-checking testbench of date_shift_by_days_unit: directed table, then random dates
// every output beat is compared against its table entry or an in-bench gregorian day-number predictor
// depends on dsd_pkg and the date_shift_by_days_unit rtl
`timescale 1ns / 100ps

module tb_date_shift_by_days_unit;

  localparam longint LAST_DAY     = longint'(dsd_pkg::DAY_NUMBER_MAX);
  localparam int     DRAIN_CYCLES = 2 * dsd_pkg::STAGES + 8;
  localparam int     RANDOM_ITEMS = 417;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] day_number;
    logic        out_of_range;
  } shifted_date_t;

  typedef struct {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] offset;
    bit                 known;
    shifted_date_t      result;
  } date_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [13:0]        year_in       = '0;
  logic [3:0]         month_in      = '0;
  logic [4:0]         day_in        = '0;
  logic signed [22:0] offset_days   = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [13:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic [21:0]        day_number_in;
  logic               out_of_range;

  shifted_date_t pending_dates[$];
  date_row_t     date_table[$];
  int            mismatches    = 0;
  int            send_idle_pct = 31;
  int            recv_idle_pct = 87;

  always #6 clk = ~clk;

  date_shift_by_days_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .year_in_i      (year_in),
    .month_in_i     (month_in),
    .day_in_i       (day_in),
    .offset_days_i  (offset_days),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .year_out_o     (year_out),
    .month_out_o    (month_out),
    .day_out_o      (day_out),
    .day_number_in_o(day_number_in),
    .out_of_range_o (out_of_range)
  );

  function automatic longint serial_of_date(longint y, longint m, longint d);
    if (m < 3) begin
      m += 12;
      y -= 1;
    end
    return d + (153 * m - 457) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 306;
  endfunction

  function automatic shifted_date_t shift_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                               logic signed [22:0] off);
    shifted_date_t r;
    longint start, target, z, h, a, b, c, yy, mm, dd;
    r = '0;
    start = serial_of_date(longint'(y), longint'(m), longint'(d));
    target = start + longint'(off);
    r.day_number = start[21:0];
    if (target < 1 || target > LAST_DAY) begin
      r.out_of_range = 1'b1;
    end else begin
      z  = target + 306;
      h  = 100 * z - 25;
      a  = h / 3652425;
      b  = a - a / 4;
      yy = (100 * b + h) / 36525;
      c  = b + z - 365 * yy - yy / 4;
      mm = (5 * c + 456) / 153;
      dd = c - (153 * mm - 457) / 5;
      if (mm > 12) begin
        yy += 1;
        mm -= 12;
      end
      r.year  = yy[13:0];
      r.month = mm[3:0];
      r.day   = dd[4:0];
    end
    return r;
  endfunction

  task automatic add_row(input int y, input int m, input int d, input int off, input bit known,
                         input int ey, input int em, input int ed, input int edn,
                         input bit eoor);
    date_row_t row;
    row.year                = y[13:0];
    row.month               = m[3:0];
    row.day                 = d[4:0];
    row.offset              = off[22:0];
    row.known               = known;
    row.result.year         = ey[13:0];
    row.result.month        = em[3:0];
    row.result.day          = ed[4:0];
    row.result.day_number   = edn[21:0];
    row.result.out_of_range = eoor;
    date_table.push_back(row);
  endtask

  task automatic send_beat(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic signed [22:0] off, input bit known,
                           input shifted_date_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    year_in     <= y;
    month_in    <= m;
    day_in      <= d;
    offset_days <= off;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(known ? result : shift_date(y, m, d, off));
  endtask

  task automatic random_beat();
    int     kind, y, m, d, mlen, off;
    longint bound;
    kind = $urandom_range(99);
    if (kind < 10) begin
      y   = $urandom_range(16383);
      m   = $urandom_range(15);
      d   = $urandom_range(31);
      off = $urandom;
    end else begin
      y = $urandom_range(9999, 1);
      m = $urandom_range(12, 1);
      case (m)
        2:             mlen = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
        4, 6, 9, 11:   mlen = 30;
        default:       mlen = 31;
      endcase
      d = $urandom_range(mlen, 1);
      if (kind < 40) begin
        off = $urandom_range(800) - 400;
      end else if (kind < 65) begin
        off = $urandom_range(80000) - 40000;
      end else if (kind < 85) begin
        off = $urandom;
      end else begin
        // land within a few days of the first or last representable day
        bound = $urandom_range(1) ? 1 : LAST_DAY;
        off = int'(bound - serial_of_date(y, m, d) + $urandom_range(6) - 3);
      end
    end
    send_beat(y[13:0], m[3:0], d[4:0], off[22:0], 1'b0, '0);
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    shifted_date_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0d-%0d-%0d", $time,
                 year_out, month_out, day_out);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year_out", want.year, year_out);
        check_field("month_out", want.month, month_out);
        check_field("day_out", want.day, day_out);
        check_field("day_number_in", want.day_number, day_number_in);
        check_field("out_of_range", want.out_of_range, out_of_range);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    // first and last representable days, range limits, offset extremes
    add_row(1, 1, 1, 0, 1, 1, 1, 1, 1, 0);
    add_row(9999, 12, 31, 0, 1, 9999, 12, 31, 3652059, 0);
    add_row(1, 1, 1, -1, 1, 0, 0, 0, 1, 1);
    add_row(9999, 12, 31, 1, 1, 0, 0, 0, 3652059, 1);
    add_row(1, 1, 1, 3652058, 1, 9999, 12, 31, 1, 0);
    add_row(9999, 12, 31, -3652058, 1, 1, 1, 1, 3652059, 0);
    add_row(1, 1, 1, 4194303, 1, 0, 0, 0, 1, 1);
    add_row(9999, 12, 31, -4194304, 1, 0, 0, 0, 3652059, 1);
    add_row(1, 1, 1, -4194304, 1, 0, 0, 0, 1, 1);
    add_row(9999, 12, 31, 4194303, 1, 0, 0, 0, 3652059, 1);
    // leap days, century rules, year and month wrap
    add_row(2000, 3, 1, -1, 0, 0, 0, 0, 0, 0);
    add_row(1900, 3, 1, -1, 0, 0, 0, 0, 0, 0);
    add_row(2024, 2, 28, 1, 0, 0, 0, 0, 0, 0);
    add_row(2023, 12, 31, 1, 0, 0, 0, 0, 0, 0);
    add_row(2024, 1, 1, -1, 0, 0, 0, 0, 0, 0);
    add_row(5000, 6, 15, -1826000, 0, 0, 0, 0, 0, 0);
    // start dates outside the calendar
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 4194303, 0, 0, 0, 0, 0, 0);
    add_row(16383, 15, 31, 0, 0, 0, 0, 0, 0, 0);
    add_row(16383, 15, 31, -4194304, 0, 0, 0, 0, 0, 0);
    add_row(2024, 13, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(2024, 2, 31, 0, 0, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (date_table[i]) begin
      send_beat(date_table[i].year, date_table[i].month, date_table[i].day,
                date_table[i].offset, date_table[i].known, date_table[i].result);
    end

    for (int phase = 0; phase < 3; phase++) begin
      drain_pending();
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
      repeat (RANDOM_ITEMS) random_beat();
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dsd_pkg.sv
hw/rtl/dsd_ctrl.sv
hw/rtl/dsd_fwd.sv
hw/rtl/dsd_cdiv.sv
hw/rtl/dsd_ymd.sv
hw/rtl/date_shift_by_days_unit.sv
sim/tb_date_shift_by_days_unit.sv
